@@ rtl/core/similar_char_pair_set_top_defines.svh @@
// Assertion macros for the similar character pair set RTL.
`ifndef SIMILAR_CHAR_PAIR_SET_TOP_DEFINES_SVH
`define SIMILAR_CHAR_PAIR_SET_TOP_DEFINES_SVH
`ifndef SYNTHESIS
// Same-cycle implication, disabled while in reset
`define SCPS_ASSERT_IMP(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("scps assertion failed");
// Next-cycle implication, disabled while in reset
`define SCPS_ASSERT_NXT(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("scps assertion failed");
`else
`define SCPS_ASSERT_IMP(lbl, clk, rst, ante, cons)
`define SCPS_ASSERT_NXT(lbl, clk, rst, ante, cons)
`endif
`endif

@@ rtl/core/scps_pkg.sv @@
// Shared types and constants for the similar character pair set.
`default_nettype none
package scps_pkg;

  // MurmurHash2 multiplier
  localparam logic [31:0] MH_M = 32'h5bd1e995;

  localparam int CODE_W = 64;
  localparam int LANES  = 2;
  localparam int QDEPTH = 2;

  typedef enum logic {
    OP_ADD  = 1'b0,
    OP_FIND = 1'b1
  } op_t;

  typedef struct packed {
    op_t               op;
    logic [CODE_W-1:0] code_a;
    logic [CODE_W-1:0] code_b;
  } cmd_t;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_HASH,
    ST_INDEX,
    ST_WRITE_A,
    ST_WRITE_B,
    ST_READ,
    ST_RESULT
  } back_state_t;

  typedef enum logic [3:0] {
    HS_LO,
    HS_KMIX0,
    HS_SEED,
    HS_HI,
    HS_KMIX1,
    HS_FOLD,
    HS_FINAL,
    HS_MOD3,
    HS_MOD2,
    HS_MOD1,
    HS_MOD0
  } hash_step_t;

endpackage
`default_nettype wire

@@ rtl/core/scps_front.sv @@
// Front stage: accepts input items and decodes the operation.
`default_nettype none
module scps_front
  import scps_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              in_valid,
  output logic                   in_ready,
  input  wire logic              in_mode,
  input  wire logic [CODE_W-1:0] in_code_a,
  input  wire logic [CODE_W-1:0] in_code_b,
  input  wire logic              hold,
  output logic                   out_valid,
  input  wire logic              out_ready,
  output cmd_t                   out_cmd
);

  logic vld;
  cmd_t cmd;

  // take a new item when not held and the stage is empty or drains this cycle
  assign in_ready  = (!vld || out_ready) && !hold;
  assign out_valid = vld;
  assign out_cmd   = cmd;

  // hold the decoded item until the queue takes it
  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= 1'b0;
    end else if (in_valid && in_ready) begin
      vld <= 1'b1;
    end else if (out_ready) begin
      vld <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      cmd.op     <= op_t'(in_mode);
      cmd.code_a <= in_code_a;
      cmd.code_b <= in_code_b;
    end
  end

endmodule
`default_nettype wire

@@ rtl/core/scps_queue.sv @@
// Short command queue between the front and back stages.
`default_nettype none
module scps_queue
  import scps_pkg::*;
(
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic push_valid,
  output logic      push_ready,
  input  wire cmd_t push_cmd,
  output logic      pop_valid,
  input  wire logic pop,
  output cmd_t      pop_cmd
);

  localparam int AW = $clog2(QDEPTH);
  localparam int CNTW = $clog2(QDEPTH + 1);

  cmd_t            entry [QDEPTH];
  logic [AW-1:0]   wr_ptr;
  logic [AW-1:0]   rd_ptr;
  logic [CNTW-1:0] count;
  logic            do_push;
  logic            do_pop;

  assign push_ready = (count != CNTW'(QDEPTH));
  assign pop_valid  = (count != '0);
  assign pop_cmd    = entry[rd_ptr];
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop && pop_valid;

  // advance pointers and occupancy
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      if (do_push && !do_pop) begin
        count <= count + 1'b1;
      end else if (do_pop && !do_push) begin
        count <= count - 1'b1;
      end
    end
  end

  // store the pushed item
  always_ff @(posedge clk) begin
    if (do_push) begin
      entry[wr_ptr] <= push_cmd;
    end
  end

endmodule
`default_nettype wire

@@ rtl/core/scps_hash.sv @@
// Sequenced MurmurHash2 of both codes with byte-wise modulo reduction.
`default_nettype none
module scps_hash
  import scps_pkg::*;
#(
  parameter int MATRIX_SIZE = 256,
  localparam int HW = $clog2(MATRIX_SIZE),
  localparam int RW = HW + 1
)(
  input  wire logic                    clk,
  input  wire logic                    rst,
  input  wire logic                    start,
  input  wire logic [LANES*CODE_W-1:0] codes,
  input  wire logic [31:0]             seed,
  output logic                         done,
  output logic [LANES*HW-1:0]          hashes
);

  localparam logic [RW-1:0] MOD_C = RW'(MATRIX_SIZE);

  logic       busy;
  hash_step_t step;
  hash_step_t step_next;

  // step sequence: seven multiplies, then four remainder bytes
  always_comb begin
    unique case (step)
      HS_LO:    step_next = HS_KMIX0;
      HS_KMIX0: step_next = HS_SEED;
      HS_SEED:  step_next = HS_HI;
      HS_HI:    step_next = HS_KMIX1;
      HS_KMIX1: step_next = HS_FOLD;
      HS_FOLD:  step_next = HS_FINAL;
      HS_FINAL: step_next = HS_MOD3;
      HS_MOD3:  step_next = HS_MOD2;
      HS_MOD2:  step_next = HS_MOD1;
      HS_MOD1:  step_next = HS_MOD0;
      HS_MOD0:  step_next = HS_LO;
      default:  step_next = HS_LO;
    endcase
  end

  // sequencer control
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      step <= HS_LO;
      done <= 1'b0;
    end else begin
      done <= busy && (step == HS_MOD0);
      if (start) begin
        busy <= 1'b1;
        step <= HS_LO;
      end else if (busy) begin
        step <= step_next;
        if (step == HS_MOD0) begin
          busy <= 1'b0;
        end
      end
    end
  end

  for (genvar gl = 0; gl < LANES; gl++) begin : g_lane
    logic [CODE_W-1:0] code_q;
    logic [31:0]       t_q;
    logic [31:0]       h_q;
    logic [RW-1:0]     rem_q;
    logic [31:0]       mul_in;
    logic [31:0]       prod;
    logic [7:0]        byte_sel;
    logic [RW-1:0]     rem_acc;

    // select the multiplier operand for this step
    always_comb begin
      unique case (step) inside
        HS_LO:              mul_in = code_q[31:0];
        HS_KMIX0, HS_KMIX1: mul_in = t_q ^ (t_q >> 24);
        HS_SEED:            mul_in = seed ^ 32'd8;
        HS_HI:              mul_in = code_q[63:32];
        HS_FOLD:            mul_in = h_q;
        HS_FINAL:           mul_in = h_q ^ (h_q >> 13);
        default:            mul_in = '0;
      endcase
      prod = mul_in * MH_M;
    end

    // reduce one hash byte, most significant first
    always_comb begin
      unique case (step) inside
        HS_MOD3: byte_sel = h_q[31:24];
        HS_MOD2: byte_sel = h_q[23:16];
        HS_MOD1: byte_sel = h_q[15:8];
        default: byte_sel = h_q[7:0];
      endcase
      rem_acc = (step == HS_MOD3) ? '0 : rem_q;
      for (int j = 7; j >= 0; j--) begin
        rem_acc = {rem_acc[RW-2:0], byte_sel[j]};
        if (rem_acc >= MOD_C) begin
          rem_acc = rem_acc - MOD_C;
        end
      end
    end

    // latch the code and update the lane registers
    always_ff @(posedge clk) begin
      if (start) begin
        code_q <= codes[gl*CODE_W +: CODE_W];
      end else if (busy) begin
        unique case (step) inside
          HS_LO, HS_KMIX0, HS_HI, HS_KMIX1: t_q <= prod;
          HS_SEED, HS_FOLD:                  h_q <= prod ^ t_q;
          HS_FINAL:                          h_q <= prod ^ (prod >> 15);
          default:                           rem_q <= rem_acc;
        endcase
      end
    end

    assign hashes[gl*HW +: HW] = rem_q[HW-1:0];
  end

endmodule
`default_nettype wire

@@ rtl/core/scps_back.sv @@
// Back stage: clears the cell store, marks and looks up pair cells.
`default_nettype none
`include "similar_char_pair_set_top_defines.svh"
module scps_back
  import scps_pkg::*;
#(
  parameter int MATRIX_SIZE = 256,
  localparam int HW = $clog2(MATRIX_SIZE)
)(
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          q_valid,
  input  wire cmd_t          q_cmd,
  output logic               q_pop,
  output logic               hash_start,
  input  wire logic          hash_done,
  input  wire logic [HW-1:0] h1,
  input  wire logic [HW-1:0] h2,
  output logic               clearing,
  output logic               out_valid,
  input  wire logic          out_ready,
  output logic               out_found
);

  localparam int CELLS = MATRIX_SIZE * MATRIX_SIZE;
  localparam int CW = $clog2(CELLS);
  localparam logic [CW-1:0] SIZE_C    = CW'(MATRIX_SIZE);
  localparam logic [CW-1:0] LAST_CELL = CW'(CELLS - 1);

  back_state_t   state;
  back_state_t   state_next;
  logic [CW-1:0] clr_addr;
  op_t           mode_q;
  logic [CW-1:0] idx_ab;
  logic [CW-1:0] idx_ba;
  logic [CW-1:0] h1_w;
  logic [CW-1:0] h2_w;
  logic          rd_bit;
  logic          mem [CELLS];
  logic          mem_we;
  logic [CW-1:0] mem_waddr;
  logic          mem_wdata;
  logic          mem_re;
  logic          out_load;

  assign h1_w = CW'(h1);
  assign h2_w = CW'(h2);

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      ST_CLEAR:   if (clr_addr == LAST_CELL) state_next = ST_IDLE;
      ST_IDLE:    if (q_valid) state_next = ST_HASH;
      ST_HASH:    if (hash_done) state_next = ST_INDEX;
      ST_INDEX:   state_next = (mode_q == OP_ADD) ? ST_WRITE_A : ST_READ;
      ST_WRITE_A: state_next = ST_WRITE_B;
      ST_WRITE_B: state_next = ST_IDLE;
      ST_READ:    state_next = ST_RESULT;
      ST_RESULT:  if (!out_valid || out_ready) state_next = ST_IDLE;
      default:    state_next = ST_IDLE;
    endcase
  end

  // state outputs
  always_comb begin
    q_pop     = 1'b0;
    mem_we    = 1'b0;
    mem_waddr = idx_ab;
    mem_wdata = 1'b1;
    mem_re    = 1'b0;
    out_load  = 1'b0;
    unique case (state)
      ST_CLEAR: begin
        mem_we    = 1'b1;
        mem_waddr = clr_addr;
        mem_wdata = 1'b0;
      end
      ST_IDLE:    q_pop = q_valid;
      ST_WRITE_A: mem_we = 1'b1;
      ST_WRITE_B: begin
        mem_we    = 1'b1;
        mem_waddr = idx_ba;
      end
      ST_READ:    mem_re = 1'b1;
      ST_RESULT:  out_load = !out_valid || out_ready;
      default:    q_pop = 1'b0;
    endcase
  end

  assign hash_start = q_pop;
  assign clearing   = (state == ST_CLEAR);

  // control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_CLEAR;
      clr_addr  <= '0;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (state == ST_CLEAR) begin
        clr_addr <= clr_addr + 1'b1;
      end
      if (out_load) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // item payload and cell addresses
  always_ff @(posedge clk) begin
    if (q_pop) begin
      mode_q <= q_cmd.op;
    end
    if (state == ST_INDEX) begin
      idx_ab <= h1_w * SIZE_C + h2_w;
      idx_ba <= h2_w * SIZE_C + h1_w;
    end
    if (out_load) begin
      out_found <= rd_bit;
    end
  end

  // cell store
  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (mem_re) begin
      rd_bit <= mem[idx_ab];
    end
  end

  `SCPS_ASSERT_IMP(a_no_pop_in_clear, clk, rst, state == ST_CLEAR, !q_pop)
  `SCPS_ASSERT_IMP(a_done_in_hash, clk, rst, hash_done, state == ST_HASH)
  `SCPS_ASSERT_NXT(a_mirror_write, clk, rst, state == ST_WRITE_A, state == ST_WRITE_B)
  `SCPS_ASSERT_NXT(a_result_shown, clk, rst, out_load, out_valid)

endmodule
`default_nettype wire

@@ rtl/core/similar_char_pair_set_top.sv @@
// Top level of the similar character pair set.
//
//  channel   direction  handshake               payload
//  s_axis    in         s_axis_tvalid/tready    tuser: mode; tdata: code_a, code_b
//  m_axis    out        m_axis_tvalid/tready    tdata: found
//  cfg       in         cfg_valid/cfg_ready     cfg_data: hash_seed
//
// An item passes through the back stage in order: the start, the hash
// sequencer (seven dependent 32-bit multiplies per code, then four remainder
// bytes), the done flag, the cell address, then two cell writes for an add
// or a read and a result for a find. The hash sequencer sets the rate.
// After reset all MATRIX_SIZE^2 cells of the store (65536 by default) are swept,
// one cell a cycle; no item is taken until the sweep ends.
// Two queued items and one front register let the input run ahead of the back
// stage; a waiting result holds the back stage only when the next find is done.
`default_nettype none
module similar_char_pair_set_top
  import scps_pkg::*;
#(
  parameter int MATRIX_SIZE = 256
)(
  input  wire logic         clk,
  input  wire logic         rst,
  input  wire logic         s_axis_tvalid,
  output logic              s_axis_tready,
  input  wire logic [127:0] s_axis_tdata,  // [63:0] code_a, [127:64] code_b
  input  wire logic [0:0]   s_axis_tuser,  // [0] mode
  output logic              m_axis_tvalid,
  input  wire logic         m_axis_tready,
  output logic [7:0]        m_axis_tdata,  // [0] found, [7:1] zero
  input  wire logic         cfg_valid,
  output logic              cfg_ready,
  input  wire logic [31:0]  cfg_data
);

  localparam int HW = $clog2(MATRIX_SIZE);

  logic                    front_valid;
  logic                    queue_ready;
  cmd_t                    front_cmd;
  logic                    q_valid;
  logic                    q_pop;
  cmd_t                    q_cmd;
  logic                    hash_start;
  logic                    hash_done;
  logic [LANES*HW-1:0]     hashes;
  logic                    clearing;
  logic                    found;
  logic [31:0]             hash_seed;

  // seed register
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      hash_seed <= '0;
    end else if (cfg_valid && cfg_ready) begin
      hash_seed <= cfg_data;
    end
  end

  scps_front u_front (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (s_axis_tvalid),
    .in_ready  (s_axis_tready),
    .in_mode   (s_axis_tuser[0]),
    .in_code_a (s_axis_tdata[63:0]),
    .in_code_b (s_axis_tdata[127:64]),
    .hold      (clearing),
    .out_valid (front_valid),
    .out_ready (queue_ready),
    .out_cmd   (front_cmd)
  );

  scps_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push_valid (front_valid),
    .push_ready (queue_ready),
    .push_cmd   (front_cmd),
    .pop_valid  (q_valid),
    .pop        (q_pop),
    .pop_cmd    (q_cmd)
  );

  scps_hash #(
    .MATRIX_SIZE (MATRIX_SIZE)
  ) u_hash (
    .clk    (clk),
    .rst    (rst),
    .start  (hash_start),
    .codes  ({q_cmd.code_b, q_cmd.code_a}),
    .seed   (hash_seed),
    .done   (hash_done),
    .hashes (hashes)
  );

  scps_back #(
    .MATRIX_SIZE (MATRIX_SIZE)
  ) u_back (
    .clk        (clk),
    .rst        (rst),
    .q_valid    (q_valid),
    .q_cmd      (q_cmd),
    .q_pop      (q_pop),
    .hash_start (hash_start),
    .hash_done  (hash_done),
    .h1         (hashes[HW-1:0]),
    .h2         (hashes[2*HW-1:HW]),
    .clearing   (clearing),
    .out_valid  (m_axis_tvalid),
    .out_ready  (m_axis_tready),
    .out_found  (found)
  );

  assign m_axis_tdata = {7'd0, found};

endmodule
`default_nettype wire

@@ tb/similar_char_pair_set_top_tb.sv @@
// Self-checking testbench for the similar character pair set: hashed pair adds and finds.
`timescale 1ns / 1ps
module similar_char_pair_set_top_tb
  import scps_pkg::*;
();

  localparam int MATRIX       = 256;
  localparam logic [31:0] MIX = 32'h5bd1e995;
  localparam int DRAIN_CYCLES = 100;     // time for trailing adds to finish in the back stage
  localparam int HOLD_CYCLES  = 600;
  localparam int IDLE_LIMIT   = 300000;  // covers the store sweep after reset
  localparam int POOL_MAX     = 256;

  typedef struct {
    logic [63:0] a;
    logic [63:0] b;
  } code_pair_t;

  logic         clk;
  logic         rst;
  logic         s_axis_tvalid;
  logic         s_axis_tready;
  logic [127:0] s_axis_tdata;   // [63:0] code_a, [127:64] code_b
  logic [0:0]   s_axis_tuser;   // [0] mode
  logic         m_axis_tvalid;
  logic         m_axis_tready;
  logic [7:0]   m_axis_tdata;   // [0] found, [7:1] zero
  logic         cfg_valid;
  logic         cfg_ready;
  logic [31:0]  cfg_data;

  // Predictor state: seed and the symmetric pair matrix
  logic [31:0]       seed_now;
  bit [MATRIX-1:0]   pair_rows [MATRIX];
  bit                expected_found [$];
  code_pair_t        pair_pool [$];

  int  errors = 0;
  int  tx_idle_pct;
  int  rx_stall_pct;
  int  idle_cycles = 0;
  bit  rx_hold;
  event hold_kick;

  similar_char_pair_set_top u_top (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_data      (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  function automatic void log_error(string what);
    errors++;
    if (errors <= 10) $display("ERROR at %0t: %s", $time, what);
  endfunction

  // MurmurHash2 of one 64-bit code, bytes taken little-endian
  function automatic logic [31:0] mix_code(logic [63:0] code, logic [31:0] seed);
    logic [31:0] h;
    logic [31:0] k;
    h = seed ^ 32'd8;
    for (int blk = 0; blk < 2; blk++) begin
      k = code[32*blk +: 32];
      k = k * MIX;
      k = k ^ (k >> 24);
      k = k * MIX;
      h = h * MIX;
      h = h ^ k;
    end
    h = h ^ (h >> 13);
    h = h * MIX;
    h = h ^ (h >> 15);
    return h;
  endfunction

  function automatic int unsigned bucket_of(logic [63:0] code);
    return mix_code(code, seed_now) % MATRIX;
  endfunction

  // Mark both cells for an add, queue the answer for a find
  function automatic void track_pair(op_t op, logic [63:0] a, logic [63:0] b);
    int unsigned r;
    int unsigned c;
    r = bucket_of(a);
    c = bucket_of(b);
    if (op == OP_ADD) begin
      pair_rows[r][c] = 1'b1;
      pair_rows[c][r] = 1'b1;
    end else begin
      expected_found.push_back(pair_rows[r][c]);
    end
  endfunction

  function automatic logic [63:0] rand_code();
    case ($urandom_range(3))
      0: return {48'd0, 16'($urandom)};
      1: return {32'd0, 32'($urandom)};
      default: return {32'($urandom), 32'($urandom)};
    endcase
  endfunction

  // Offer one item, idling first at the current rate, and hold until taken
  task automatic send_pair(op_t op, logic [63:0] a, logic [63:0] b);
    while (tx_idle_pct != 0 && $urandom_range(99) < tx_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {b, a};
    s_axis_tuser  <= op;
    do @(posedge clk); while (!s_axis_tready);
    track_pair(op, a, b);
  endtask

  // Drop valid, wait for every answer, then let trailing adds finish
  task automatic wait_idle();
    s_axis_tvalid <= 1'b0;
    while (expected_found.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_seed(logic [31:0] value);
    wait_idle();
    cfg_valid <= 1'b1;
    cfg_data  <= value;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    seed_now = value;
  endtask

  task automatic send_random_items(int count);
    code_pair_t p;
    op_t op;
    for (int n = 0; n < count; n++) begin
      op = ($urandom_range(99) < 40) ? OP_ADD : OP_FIND;
      if (op == OP_FIND && pair_pool.size() != 0 && $urandom_range(99) < 55) begin
        p = pair_pool[$urandom_range(pair_pool.size() - 1)];
        if ($urandom_range(1) == 1) p = '{p.b, p.a};
      end else begin
        p.a = rand_code();
        p.b = rand_code();
      end
      if (op == OP_ADD) begin
        if (pair_pool.size() < POOL_MAX) pair_pool.push_back(p);
        else pair_pool[$urandom_range(POOL_MAX - 1)] = p;
      end
      send_pair(op, p.a, p.b);
    end
  endtask

  // Extremes, symmetry, duplicates, diagonal cell and empty set, at both seed extremes
  task automatic test_directed();
    logic [63:0] ones;
    logic [63:0] x;
    logic [63:0] y;
    ones = '1;
    x    = 64'h0123456789abcdef;
    tx_idle_pct  = 0;
    rx_stall_pct = 0;
    // reset seed: the set starts empty
    send_pair(OP_FIND, 64'd0, 64'd0);
    send_pair(OP_FIND, ones, 64'h8000000000000000);
    send_pair(OP_ADD, 64'd0, ones);
    send_pair(OP_FIND, 64'd0, ones);
    send_pair(OP_FIND, ones, 64'd0);
    send_pair(OP_ADD, 64'd0, ones);
    send_pair(OP_FIND, 64'd0, ones);
    send_pair(OP_ADD, x, x);
    send_pair(OP_FIND, x, x);
    // a distinct code landing in the same bucket shares the diagonal cell
    do y = {32'($urandom), 32'($urandom)}; while (y == x || bucket_of(y) != bucket_of(x));
    send_pair(OP_FIND, x, y);
    send_pair(OP_FIND, y, y);
    send_pair(OP_ADD, 64'h8000000000000000, 64'd1);
    send_pair(OP_FIND, 64'd1, 64'h8000000000000000);
    wait_idle();
    write_seed(32'hffffffff);
    send_pair(OP_FIND, 64'd0, ones);
    send_pair(OP_FIND, x, x);
    send_pair(OP_ADD, 64'ha5a5a5a5a5a5a5a5, 64'h5a5a5a5a5a5a5a5a);
    send_pair(OP_FIND, 64'h5a5a5a5a5a5a5a5a, 64'ha5a5a5a5a5a5a5a5);
    send_pair(OP_ADD, ones, ones);
    send_pair(OP_FIND, ones, ones);
    send_pair(OP_FIND, 64'h8000000000000000, 64'd1);
    wait_idle();
  endtask

  task automatic test_streaming();
    write_seed($urandom);
    tx_idle_pct  = 0;
    rx_stall_pct = 0;
    send_random_items(400);
    wait_idle();
  endtask

  task automatic test_sender_gaps();
    write_seed(32'd0);
    tx_idle_pct  = 85;
    rx_stall_pct = 0;
    send_random_items(300);
    wait_idle();
  endtask

  task automatic test_receiver_stalls();
    write_seed(32'hffffffff);
    tx_idle_pct  = 0;
    rx_stall_pct = 85;
    send_random_items(300);
    wait_idle();
  endtask

  task automatic test_mixed_gaps();
    write_seed($urandom);
    tx_idle_pct  = 22;
    rx_stall_pct = 22;
    send_random_items(400);
    wait_idle();
  endtask

  // Hold the result side off so the input queue fills and backs up
  task automatic test_backpressure();
    tx_idle_pct  = 0;
    rx_stall_pct = 0;
    -> hold_kick;
    send_random_items(180);
    wait_idle();
  endtask

  // Long receiver hold, timed in its own process
  initial begin
    rx_hold = 1'b0;
    forever begin
      @(hold_kick);
      rx_hold <= 1'b1;
      repeat (HOLD_CYCLES) @(posedge clk);
      rx_hold <= 1'b0;
    end
  end

  // Receiver ready pattern
  always @(posedge clk) begin
    m_axis_tready <= !rx_hold && ($urandom_range(99) >= rx_stall_pct);
  end

  // Compare each answer with the oldest expectation
  always @(posedge clk) begin
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      if (expected_found.size() == 0) begin
        log_error($sformatf("unexpected result, found=%0d", m_axis_tdata[0]));
      end else if (m_axis_tdata[0] !== expected_found[0]) begin
        log_error($sformatf("found mismatch: expected %0d, got %0d",
                            expected_found[0], m_axis_tdata[0]));
        void'(expected_found.pop_front());
      end else begin
        void'(expected_found.pop_front());
      end
    end
  end

  // Watchdog: end the run if nothing moves for too long
  always @(posedge clk) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
        (cfg_valid && cfg_ready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("timeout: no item moved for %0d cycles", IDLE_LIMIT);
      $display("similar_char_pair_set_top test failed");
      $finish;
    end
  end

  initial begin
    tx_idle_pct  = 0;
    rx_stall_pct = 0;
    seed_now     = 32'd0;
    foreach (pair_rows[r]) pair_rows[r] = '0;
    rst           <= 1'b1;
    s_axis_tvalid <= 1'b0;
    s_axis_tdata  <= '0;
    s_axis_tuser  <= '0;
    cfg_valid     <= 1'b0;
    cfg_data      <= '0;
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_directed();
    test_streaming();
    test_sender_gaps();
    test_receiver_stalls();
    test_mixed_gaps();
    test_backpressure();
    wait_idle();

    if (errors == 0) begin
      $display("similar_char_pair_set_top test passed");
    end else begin
      $display("similar_char_pair_set_top test failed");
    end
    $finish;
  end

endmodule

@@ similar_char_pair_set_top.f @@
+incdir+rtl/core
rtl/core/scps_pkg.sv
rtl/core/scps_front.sv
rtl/core/scps_queue.sv
rtl/core/scps_hash.sv
rtl/core/scps_back.sv
rtl/core/similar_char_pair_set_top.sv
tb/similar_char_pair_set_top_tb.sv
